// ----- rtl/shad_pkg.sv -----
package shad_pkg;

   typedef logic [7:0][31:0] chain_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [7:0] digest_byte;
      logic [4:0] byte_index;
      logic       last_byte;
   } rsp_word_type;

   // command from the message sequencer to the compression unit
   typedef struct packed {
      logic start;
      logic init_iv;
      logic zero_blk;
   } cmp_ctl_type;

   localparam logic [5:0]  DigestBytesReset = 6'd32;
   localparam logic [5:0]  DigestBytesMin   = 6'd2;
   localparam logic [5:0]  DigestBytesMax   = 6'd32;
   localparam logic [63:0] ZeroBlockBits    = 64'd512;
   localparam logic [63:0] BlockBits        = 64'd512;
   localparam logic [31:0] PadWord          = 32'h8000_0000;
   localparam logic [7:0]  PadByte          = 8'h80;
   localparam logic [31:0] OuterLenWord     = 32'd256;
   localparam logic [3:0]  LenHiIdx         = 4'd14;
   localparam logic [3:0]  LenLoIdx         = 4'd15;
   localparam logic [3:0]  OuterPadIdx      = 4'd8;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic chain_type iv_words();
      chain_type v;
      v[0] = 32'h6a09e667; v[1] = 32'hbb67ae85; v[2] = 32'h3c6ef372; v[3] = 32'ha54ff53a;
      v[4] = 32'h510e527f; v[5] = 32'h9b05688c; v[6] = 32'h1f83d9ab; v[7] = 32'h5be0cd19;
      return v;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] r);
      logic [31:0] k;
      case (r)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

// ----- rtl/shad_compress.sv -----
module shad_compress (
   input  logic                   clock,
   input  logic                   reset,
   input  shad_pkg::cmp_ctl_type  ctl,
   input  logic [31:0]            rd_data,
   output logic [3:0]             rd_addr,
   output logic                   done,
   output shad_pkg::chain_type    chain
);

   typedef enum logic [1:0] {P_IDLE, P_LOAD, P_ROUND, P_ADD} phase_type;

   phase_type            phase_ff;
   logic [5:0]           cnt_ff;
   logic                 zero_ff;
   logic                 done_ff;
   shad_pkg::chain_type  vars_ff, vars_in;
   shad_pkg::chain_type  chain_ff;
   logic [15:0][31:0]    win_ff;
   logic [31:0]          w_new;

   always_comb begin
      logic [31:0] a, e, s1, s0, ch, mj, t1, t2, g0, g1;
      a  = vars_ff[0];
      e  = vars_ff[4];
      s1 = shad_pkg::rotr(e, 6) ^ shad_pkg::rotr(e, 11) ^ shad_pkg::rotr(e, 25);
      ch = (e & vars_ff[5]) ^ (~e & vars_ff[6]);
      t1 = vars_ff[7] + s1 + ch + shad_pkg::round_k(cnt_ff) + win_ff[0];
      s0 = shad_pkg::rotr(a, 2) ^ shad_pkg::rotr(a, 13) ^ shad_pkg::rotr(a, 22);
      mj = (a & vars_ff[1]) ^ (a & vars_ff[2]) ^ (vars_ff[1] & vars_ff[2]);
      t2 = s0 + mj;
      vars_in[7] = vars_ff[6];
      vars_in[6] = vars_ff[5];
      vars_in[5] = e;
      vars_in[4] = vars_ff[3] + t1;
      vars_in[3] = vars_ff[2];
      vars_in[2] = vars_ff[1];
      vars_in[1] = a;
      vars_in[0] = t1 + t2;
      // next schedule word, window holds w[r..r+15]
      g1 = shad_pkg::rotr(win_ff[14], 17) ^ shad_pkg::rotr(win_ff[14], 19) ^ (win_ff[14] >> 10);
      g0 = shad_pkg::rotr(win_ff[1], 7) ^ shad_pkg::rotr(win_ff[1], 18) ^ (win_ff[1] >> 3);
      w_new = g1 + win_ff[9] + g0 + win_ff[0];
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      case (phase_ff)
         P_IDLE: begin
            if (ctl.start) begin
               if (ctl.init_iv) begin
                  chain_ff <= shad_pkg::iv_words();
                  vars_ff  <= shad_pkg::iv_words();
               end else begin
                  vars_ff <= chain_ff;
               end
               zero_ff  <= ctl.zero_blk;
               cnt_ff   <= '0;
               phase_ff <= P_LOAD;
            end
         end
         P_LOAD: begin
            // read data arrives in the cycle after its address
            if (cnt_ff != 6'd0) begin
               win_ff[14:0] <= win_ff[15:1];
               win_ff[15]   <= zero_ff ? 32'h0 : rd_data;
            end
            if (cnt_ff == 6'd16) begin
               cnt_ff   <= '0;
               phase_ff <= P_ROUND;
            end else begin
               cnt_ff <= cnt_ff + 6'd1;
            end
         end
         P_ROUND: begin
            vars_ff      <= vars_in;
            win_ff[14:0] <= win_ff[15:1];
            win_ff[15]   <= w_new;
            if (cnt_ff == 6'd63) begin
               phase_ff <= P_ADD;
            end
            cnt_ff <= cnt_ff + 6'd1;
         end
         P_ADD: begin
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= chain_ff[i] + vars_ff[i];
            end
            done_ff  <= 1'b1;
            phase_ff <= P_IDLE;
         end
         default: phase_ff <= P_IDLE;
      endcase
      if (reset) begin
         phase_ff <= P_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end
   end

   assign rd_addr = cnt_ff[3:0];
   assign done    = done_ff;
   assign chain   = chain_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> phase_ff == P_IDLE)
      else $error("compression started while busy");
   a_done_after_add: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(phase_ff) == P_ADD)
      else $error("done without final add");
   a_round_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == P_LOAD |-> cnt_ff <= 6'd16)
      else $error("load count overran");

endmodule

// ----- rtl/shad256_hash_engine.sv -----
// channel | ports                           | direction | payload
// request | req_valid req_stall req_word    | in        | data_byte byte_valid last
// result  | rsp_valid rsp_stall rsp_word    | out       | digest_byte byte_index last_byte
// config  | csr_wr_en csr_wr_data           | in        | digest_bytes
// bytes are taken while req_stall is low; each 64th byte starts the one-round-per-cycle
// compression unit (block memory read, 64 rounds, chain add, done handoff)
// a last item costs up to three compressions plus padding writes, then one digest word
// per cycle while rsp_stall is low; after reset and after each digest the zero block
// is compressed before req_stall drops; reset is synchronous, active high
module shad256_hash_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  shad_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output shad_pkg::rsp_word_type rsp_word,
   input  logic                   csr_wr_en,
   input  logic [5:0]             csr_wr_data
);

   typedef enum logic [3:0] {
      S_INIT, S_WAITI, S_IDLE, S_BLK, S_FIN, S_PAD, S_PWAIT,
      S_LEN, S_WINNER, S_OUTER, S_WOUTER, S_EMIT
   } state_type;

   state_type              state_ff;
   logic [5:0]             fill_ff;
   logic [23:0]            pack_ff;
   logic [63:0]            bitlen_ff;
   logic                   pend_last_ff;
   logic [3:0]             wptr_ff;
   logic                   ovf_ff;
   logic [5:0]             ecnt_ff;
   logic [5:0]             dbytes_ff;
   logic                   rsp_valid_ff;
   shad_pkg::rsp_word_type rsp_word_ff;

   logic [31:0]            mem [16];
   logic [31:0]            rd_data_ff;
   logic [3:0]             rd_addr;
   logic                   we;
   logic [3:0]             waddr;
   logic [31:0]            wdata;

   shad_pkg::cmp_ctl_type  ctl;
   logic                   cmp_done;
   shad_pkg::chain_type    chain;

   logic [5:0]             nbytes;
   logic [31:0]            pad_word;
   logic [31:0]            outer_word;
   logic [31:0]            emit_word;
   logic                   accept;

   shad_compress u_compress (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_data (rd_data_ff),
      .rd_addr (rd_addr),
      .done    (cmp_done),
      .chain   (chain)
   );

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign accept = req_valid && !req_stall;
   assign nbytes = (dbytes_ff < shad_pkg::DigestBytesMin) ? shad_pkg::DigestBytesMin :
                   (dbytes_ff > shad_pkg::DigestBytesMax) ? shad_pkg::DigestBytesMax : dbytes_ff;

   always_comb begin
      case (fill_ff[1:0])
         2'd0:    pad_word = shad_pkg::PadWord;
         2'd1:    pad_word = {pack_ff[7:0], shad_pkg::PadByte, 16'h0};
         2'd2:    pad_word = {pack_ff[15:0], shad_pkg::PadByte, 8'h0};
         2'd3:    pad_word = {pack_ff[23:0], shad_pkg::PadByte};
         default: pad_word = shad_pkg::PadWord;
      endcase
      if (wptr_ff < shad_pkg::OuterPadIdx) begin
         outer_word = chain[wptr_ff[2:0]];
      end else if (wptr_ff == shad_pkg::OuterPadIdx) begin
         outer_word = shad_pkg::PadWord;
      end else if (wptr_ff == shad_pkg::LenLoIdx) begin
         outer_word = shad_pkg::OuterLenWord;
      end else begin
         outer_word = 32'h0;
      end
      emit_word = chain[ecnt_ff[4:2]];
   end

   always_comb begin
      we    = 1'b0;
      waddr = wptr_ff;
      wdata = 32'h0;
      ctl   = '0;
      case (state_ff)
         S_INIT: begin
            ctl.start    = 1'b1;
            ctl.init_iv  = 1'b1;
            ctl.zero_blk = 1'b1;
         end
         S_IDLE: begin
            if (accept && req_word.byte_valid && fill_ff[1:0] == 2'd3) begin
               we    = 1'b1;
               waddr = fill_ff[5:2];
               wdata = {pack_ff, req_word.data_byte};
            end
            if (accept && req_word.byte_valid && fill_ff == 6'd63) begin
               ctl.start = 1'b1;
            end
         end
         S_FIN: begin
            we    = 1'b1;
            waddr = fill_ff[5:2];
            wdata = pad_word;
         end
         S_PAD: begin
            if (ovf_ff && wptr_ff == 4'd0) begin
               ctl.start = 1'b1;
            end else if (!(!ovf_ff && wptr_ff == shad_pkg::LenHiIdx)) begin
               we = 1'b1;
            end
         end
         S_LEN: begin
            we    = 1'b1;
            wdata = (wptr_ff == shad_pkg::LenHiIdx) ? bitlen_ff[63:32] : bitlen_ff[31:0];
            ctl.start = (wptr_ff == shad_pkg::LenLoIdx);
         end
         S_OUTER: begin
            we    = 1'b1;
            wdata = outer_word;
            if (wptr_ff == shad_pkg::LenLoIdx) begin
               ctl.start   = 1'b1;
               ctl.init_iv = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (csr_wr_en) begin
         dbytes_ff <= csr_wr_data;
      end
      case (state_ff)
         S_INIT: begin
            fill_ff   <= '0;
            bitlen_ff <= shad_pkg::ZeroBlockBits;
            state_ff  <= S_WAITI;
         end
         S_WAITI: begin
            if (cmp_done) begin
               state_ff <= S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_word.byte_valid) begin
                  pack_ff <= {pack_ff[15:0], req_word.data_byte};
                  fill_ff <= fill_ff + 6'd1;
               end
               pend_last_ff <= req_word.last;
               if (req_word.byte_valid && fill_ff == 6'd63) begin
                  bitlen_ff <= bitlen_ff + shad_pkg::BlockBits;
                  state_ff  <= S_BLK;
               end else if (req_word.last) begin
                  state_ff <= S_FIN;
               end
            end
         end
         S_BLK: begin
            if (cmp_done) begin
               state_ff <= pend_last_ff ? S_FIN : S_IDLE;
            end
         end
         S_FIN: begin
            bitlen_ff <= bitlen_ff + {55'h0, fill_ff, 3'b000};
            wptr_ff   <= fill_ff[5:2] + 4'd1;
            ovf_ff    <= (fill_ff[5:2] >= shad_pkg::LenHiIdx);
            state_ff  <= S_PAD;
         end
         S_PAD: begin
            if (ovf_ff && wptr_ff == 4'd0) begin
               ovf_ff   <= 1'b0;
               state_ff <= S_PWAIT;
            end else if (!ovf_ff && wptr_ff == shad_pkg::LenHiIdx) begin
               state_ff <= S_LEN;
            end else begin
               wptr_ff <= wptr_ff + 4'd1;
            end
         end
         S_PWAIT: begin
            if (cmp_done) begin
               state_ff <= S_PAD;
            end
         end
         S_LEN: begin
            wptr_ff <= wptr_ff + 4'd1;
            if (wptr_ff == shad_pkg::LenLoIdx) begin
               state_ff <= S_WINNER;
            end
         end
         S_WINNER: begin
            if (cmp_done) begin
               wptr_ff  <= '0;
               state_ff <= S_OUTER;
            end
         end
         S_OUTER: begin
            wptr_ff <= wptr_ff + 4'd1;
            if (wptr_ff == shad_pkg::LenLoIdx) begin
               state_ff <= S_WOUTER;
            end
         end
         S_WOUTER: begin
            if (cmp_done) begin
               ecnt_ff  <= '0;
               state_ff <= S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if (ecnt_ff < nbytes) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_word_ff.digest_byte <= emit_word[8 * (3 - ecnt_ff[1:0]) +: 8];
                  rsp_word_ff.byte_index  <= ecnt_ff[4:0];
                  rsp_word_ff.last_byte   <= (ecnt_ff + 6'd1 == nbytes);
                  ecnt_ff                 <= ecnt_ff + 6'd1;
               end else begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_INIT;
               end
            end
         end
         default: state_ff <= S_INIT;
      endcase
      if (reset) begin
         state_ff     <= S_INIT;
         dbytes_ff    <= shad_pkg::DigestBytesReset;
         rsp_valid_ff <= 1'b0;
         pend_last_ff <= 1'b0;
         ovf_ff       <= 1'b0;
         fill_ff      <= '0;
         ecnt_ff      <= '0;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_rsp_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_EMIT)
      else $error("digest word outside emit");
   a_ecnt_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> ecnt_ff <= nbytes)
      else $error("emit count past digest length");
   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      cmp_done |-> (state_ff == S_WAITI || state_ff == S_BLK || state_ff == S_PWAIT ||
                    state_ff == S_WINNER || state_ff == S_WOUTER))
      else $error("compression finished with nobody waiting");

endmodule

// ----- sim/shad256_hash_engine_tb.sv -----
module shad256_hash_engine_tb;

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
   localparam int DrainCycles = 400;
   localparam logic [5:0] DigestSweep [7] = '{6'd2, 6'd0, 6'd1, 6'd63, 6'd33, 6'd17, 6'd32};
   // the larger phases open with a message near a block boundary
   localparam int PhaseBudget [8] = '{16, 68, 16, 16, 68, 16, 16, 20};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   shad_pkg::req_word_type req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   shad_pkg::rsp_word_type rsp_word;
   logic                   csr_wr_en = 1'b0;
   logic [5:0]             csr_wr_data = '0;

   // hasher model state
   shad_pkg::chain_type    chain, zero_chain;
   logic [63:0][7:0]       msg_block;
   int unsigned            msg_fill;
   logic [63:0]            msg_bits;
   logic [5:0]             digest_len_cfg;
   shad_pkg::rsp_word_type digest_queue[$];

   int  fails = 0, words_in = 0, messages = 0, digest_words = 0;
   bit  quiet = 1'b0;
   int  hold_cycles = 0;

   shad256_hash_engine i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic shad_pkg::chain_type block_compress(shad_pkg::chain_type h,
                                                          logic [63:0][7:0] blk);
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      shad_pkg::chain_type res;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      for (int i = 0; i < 8; i++) v[i] = h[i];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[r];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) res[i] = h[i] + v[i];
      return res;
   endfunction

   function automatic shad_pkg::chain_type sha_iv();
      shad_pkg::chain_type h;
      for (int i = 0; i < 8; i++) h[i] = SHA_IV[i];
      return h;
   endfunction

   function automatic logic [7:0] chain_byte(shad_pkg::chain_type h, int i);
      return h[i/4][31 - 8*(i%4) -: 8];
   endfunction

   function automatic void start_message();
      chain = zero_chain;
      msg_block = '0;
      msg_fill = 0;
      msg_bits = shad_pkg::ZeroBlockBits;
   endfunction

   // absorb one accepted word, queue the digest bytes it yields
   function automatic void hash_word(shad_pkg::req_word_type wd);
      logic [7:0]   inner [32];
      int unsigned  n;
      shad_pkg::rsp_word_type r;
      if (wd.byte_valid) begin
         msg_block[msg_fill] = wd.data_byte;
         msg_fill++;
         if (msg_fill == 64) begin
            chain = block_compress(chain, msg_block);
            msg_bits += 64'd512;
            msg_fill = 0;
         end
      end
      if (!wd.last) return;
      msg_bits += 64'(msg_fill * 8);
      msg_block[msg_fill] = 8'h80;
      msg_fill++;
      if (msg_fill > 56) begin
         while (msg_fill < 64) msg_block[msg_fill++] = 8'h00;
         chain = block_compress(chain, msg_block);
         msg_fill = 0;
      end
      while (msg_fill < 56) msg_block[msg_fill++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bits[63 - 8*i -: 8];
      chain = block_compress(chain, msg_block);
      for (int i = 0; i < 32; i++) inner[i] = chain_byte(chain, i);
      msg_block = '0;
      for (int i = 0; i < 32; i++) msg_block[i] = inner[i];
      msg_block[32] = 8'h80;
      msg_block[62] = 8'h01;  // outer length 256 bits
      chain = block_compress(sha_iv(), msg_block);
      n = digest_len_cfg;
      if (n < 2) n = 2;
      if (n > 32) n = 32;
      for (int i = 0; i < n; i++) begin
         r.digest_byte = chain_byte(chain, i);
         r.byte_index  = 5'(i);
         r.last_byte   = (i + 1 == n);
         digest_queue.push_back(r);
      end
      messages++;
      start_message();
   endfunction

   // result side
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         digest_words++;
         if (digest_queue.size() == 0) begin
            $error("unexpected digest word %h", rsp_word);
            fails++;
         end else begin
            shad_pkg::rsp_word_type e;
            e = digest_queue.pop_front();
            if (rsp_word.digest_byte !== e.digest_byte) begin
               $error("digest_byte expected %h got %h", e.digest_byte, rsp_word.digest_byte);
               fails++;
            end
            if (rsp_word.byte_index !== e.byte_index) begin
               $error("byte_index expected %0d got %0d", e.byte_index, rsp_word.byte_index);
               fails++;
            end
            if (rsp_word.last_byte !== e.last_byte) begin
               $error("last_byte expected %0d got %0d", e.last_byte, rsp_word.last_byte);
               fails++;
            end
         end
      end
   end

   // receiver stall: random bursts, plus a long hold on request
   initial begin
      int burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            hold_cycles--;
         end else if (burst > 0) begin
            rsp_stall = 1'b1;
            burst--;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall = 1'b1;
            burst = $urandom_range(0, 4);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   task automatic send_word(shad_pkg::req_word_type wd);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_word = wd;
      do @(posedge clock); while (req_stall);
      hash_word(wd);
      if (wd.byte_valid || wd.last) words_in++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (digest_queue.size() != 0) @(negedge clock);
   endtask

   task automatic write_digest_len(logic [5:0] val);
      wait_drained();
      repeat (DrainCycles) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      digest_len_cfg = val;
   endtask

   task automatic send_message(int len, bit split_last);
      shad_pkg::req_word_type wd;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) send_word('0);  // idle word
         wd.data_byte = 8'($urandom);
         wd.byte_valid = 1'b1;
         wd.last = (i == len - 1) && !split_last;
         send_word(wd);
      end
      if (split_last || len == 0) send_word('{8'($urandom), 1'b0, 1'b1});
   endtask

   // message length that fits the words left in the phase
   function automatic int pick_length(int room);
      int sel;
      int edges [4] = '{55, 56, 63, 64};
      sel = $urandom_range(0, 19);
      if (room >= 64) return edges[$urandom_range(0, 3)];
      if (sel < 16 || room <= 21) return $urandom_range(0, (room < 20) ? room : 20);
      return $urandom_range(21, (room < 70) ? room : 70);
   endfunction

   shad_pkg::req_word_type directed [20] = '{
      '{8'h00, 1'b0, 1'b0},  // idle word
      '{8'h00, 1'b0, 1'b1},  // empty message
      '{8'hff, 1'b1, 1'b1},  // byte carried with last
      '{8'h00, 1'b1, 1'b1},
      '{8'haa, 1'b1, 1'b0},
      '{8'h55, 1'b1, 1'b0},
      '{8'h00, 1'b0, 1'b0},
      '{8'hff, 1'b0, 1'b1},  // separate last, data ignored
      '{8'h01, 1'b1, 1'b0},
      '{8'h80, 1'b1, 1'b0},
      '{8'h7f, 1'b1, 1'b0},
      '{8'hfe, 1'b1, 1'b1},
      '{8'h00, 1'b0, 1'b1},
      '{8'h00, 1'b0, 1'b1},
      '{8'h0f, 1'b1, 1'b0},
      '{8'hf0, 1'b1, 1'b0},
      '{8'h00, 1'b0, 1'b0},
      '{8'h3c, 1'b1, 1'b0},
      '{8'hc3, 1'b1, 1'b0},
      '{8'h5a, 1'b1, 1'b1}};

   initial begin
      int phase_items;
      int room;
      digest_len_cfg = shad_pkg::DigestBytesReset;
      zero_chain = block_compress(sha_iv(), '0);
      start_message();
      repeat (11) @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) send_word(directed[i]);

      for (int p = 0; p < 8; p++) begin
         if (p < 7) write_digest_len(p == 6 ? 6'($urandom_range(0, 63)) : DigestSweep[p]);
         quiet = (p == 7);
         phase_items = words_in + PhaseBudget[p];
         while (words_in < phase_items) begin
            room = phase_items - words_in;
            if (p == 2 && words_in + 20 > phase_items) hold_cycles = 600;
            if (p == 4 && $urandom_range(0, 2) == 0) wait_drained();
            send_message(pick_length(room), $urandom_range(0, 1));
         end
      end

      wait_drained();
      repeat (DrainCycles) @(negedge clock);
      $display("covered %0d words in %0d messages, %0d digest bytes checked",
               words_in, messages, digest_words);
      $display("digest lengths swept from clamped low to clamped high, block edges included");
      if (fails == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- shad256_hash_engine.f -----
rtl/shad_pkg.sv
rtl/shad_compress.sv
rtl/shad256_hash_engine.sv
sim/shad256_hash_engine_tb.sv
